// ===== hdl/bpc_pkg.sv =====
package bpc_pkg;

    localparam int TimeWidth  = 32;
    localparam int CfgWidth   = 16;
    localparam int IndexWidth = 2;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_DEB_PRESS  = 3'd1,
        PH_WAIT_SHORT = 3'd2,
        PH_WAIT_LONG  = 3'd3,
        PH_WAIT_REL   = 3'd4,
        PH_DEB_REL    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_CLICK      = 2'd1,
        EV_SHORT_HOLD = 2'd2,
        EV_LONG_HOLD  = 2'd3
    } event_t;

    typedef enum logic [IndexWidth-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_SHORT_HOLD = 2'd1,
        REG_LONG_HOLD  = 2'd2
    } reg_index_t;

    localparam logic [CfgWidth-1:0] DebounceReset  = 16'd50;
    localparam logic [CfgWidth-1:0] ShortHoldReset = 16'd1000;
    localparam logic [CfgWidth-1:0] LongHoldReset  = 16'd3000;

    typedef struct packed {
        logic [CfgWidth-1:0] debounce_time;
        logic [CfgWidth-1:0] short_hold_time;
        logic [CfgWidth-1:0] long_hold_time;
    } cfg_t;

endpackage

// ===== hdl/bpc_cfg_regs.sv =====
module bpc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpc_pkg::IndexWidth-1:0] cfg_index,
    input  logic [bpc_pkg::CfgWidth-1:0]   cfg_data,
    output bpc_pkg::cfg_t                 cfg
);
    import bpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_DEBOUNCE:   cfg_next.debounce_time   = cfg_data;
                REG_SHORT_HOLD: cfg_next.short_hold_time = cfg_data;
                REG_LONG_HOLD:  cfg_next.long_hold_time  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time   <= DebounceReset;
            cfg_reg.short_hold_time <= ShortHoldReset;
            cfg_reg.long_hold_time  <= LongHoldReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/bpc_fsm.sv =====
module bpc_fsm (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [bpc_pkg::TimeWidth-1:0] time_ms,
    input  logic                         pressed,
    input  bpc_pkg::cfg_t                cfg,
    output bpc_pkg::event_t              event_code
);
    import bpc_pkg::*;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [TimeWidth-1:0]   start_reg;
    logic [TimeWidth-1:0]   start_next;
    logic [TimeWidth-1:0]   elapsed;
    logic                   deb_done;
    logic                   short_done;
    logic                   long_done;

    // Elapsed time wraps modulo 2^32, so a timestamp that goes backwards
    // reads as a very long interval.
    assign elapsed    = time_ms - start_reg;
    assign deb_done   = elapsed >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.debounce_time};
    assign short_done = elapsed >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.short_hold_time};
    assign long_done  = elapsed >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.long_hold_time};

    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        event_code = EV_NONE;
        case (phase_reg)
            PH_DEB_PRESS: begin
                if (deb_done) begin
                    if (pressed) begin
                        phase_next = PH_WAIT_SHORT;
                        start_next = time_ms;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_WAIT_SHORT: begin
                if (!pressed) begin
                    event_code = EV_CLICK;
                    phase_next = PH_DEB_REL;
                    start_next = time_ms;
                end else if (short_done) begin
                    // The long hold is measured from the same start.
                    event_code = EV_SHORT_HOLD;
                    phase_next = PH_WAIT_LONG;
                end
            end
            PH_WAIT_LONG: begin
                if (!pressed) begin
                    phase_next = PH_DEB_REL;
                    start_next = time_ms;
                end else if (long_done) begin
                    event_code = EV_LONG_HOLD;
                    phase_next = PH_WAIT_REL;
                end
            end
            PH_WAIT_REL: begin
                if (!pressed) begin
                    phase_next = PH_DEB_REL;
                    start_next = time_ms;
                end
            end
            PH_DEB_REL: begin
                if (deb_done && !pressed) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                if (pressed) begin
                    phase_next = PH_DEB_PRESS;
                    start_next = time_ms;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            start_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            start_reg <= start_next;
        end
    end

endmodule

// ===== hdl/button_press_classifier.sv =====
// Each item is held in the input register and then moves to the result register.
// Throughput: one item per cycle while the output is not stalled; each item yields exactly one result item.
// The classifier state advances when an item moves from the input register to the
// result register, so a stalled output holds back the input side.
// Reset (aresetn low, synchronous) returns the machine to idle, clears the start
// time and loads the default debounce, short hold and long hold times.
module button_press_classifier (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bpc_pkg::TimeWidth-1:0]  s_time_ms,
    input  logic                           s_pressed,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_event_code,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpc_pkg::IndexWidth-1:0] cfg_index,
    input  logic [bpc_pkg::CfgWidth-1:0]   cfg_data
);
    import bpc_pkg::*;

    cfg_t                 cfg;
    event_t               event_code;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [TimeWidth-1:0] time_reg;
    logic                 pressed_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           event_reg;
    logic                 advance;
    logic                 s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign m_valid      = out_valid_reg;
    assign m_event_code = event_reg;

    bpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .time_ms    (time_reg),
        .pressed    (pressed_reg),
        .cfg        (cfg),
        .event_code (event_code)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            time_reg    <= s_time_ms;
            pressed_reg <= s_pressed;
        end
        if (advance) begin
            event_reg <= event_code;
        end
    end

endmodule
